// File: rtl/bmhq_pkg.sv
`default_nettype none

package bmhq_pkg;

  // Field widths of the words on the ports
  localparam int KEY_BITS    = 16;
  localparam int HANDLE_BITS = 10;
  localparam int CAP_BITS    = 7;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  // Opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Input word
  typedef struct packed {
    logic                   opcode;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } req_t;

  // Output word
  typedef struct packed {
    logic                   result_valid;
    logic [KEY_BITS-1:0]    out_key;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [1:0]             status;
  } rsp_t;

  // One heap slot as stored in the RAM
  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  // Read address select
  typedef enum logic [2:0] {
    RD_ROOT   = 3'd0,
    RD_LAST   = 3'd1,
    RD_PARENT = 3'd2,
    RD_LEFT   = 3'd3,
    RD_RIGHT  = 3'd4
  } rd_sel_e;

  // Write data select (address is always the current position)
  typedef enum logic [1:0] {
    WR_CUR  = 2'd0,
    WR_RD   = 2'd1,
    WR_BEST = 2'd2
  } wr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    push_start;
    logic    pop_start;
    logic    res_full;
    logic    res_empty;
    logic    res_root;
    logic    cur_load;
    logic    lch_load;
    logic    pos_up;
    logic    pos_down;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic left_ok;
    logic right_ok;
    logic up_less;
    logic dn_move;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/bmhq_ram.sv
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/bmhq_dp.sv
`default_nettype none

module bmhq_dp #(
  parameter int HEAP_DEPTH = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bmhq_pkg::req_t                  in_word_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [bmhq_pkg::CAP_BITS-1:0]   cfg_data_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output bmhq_pkg::rsp_t                       out_word_o,
  input  wire bmhq_pkg::cmd_t                  cmd_i,
  output bmhq_pkg::stat_t                      stat_o
);

  import bmhq_pkg::*;

  localparam int AW   = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW   = $clog2(HEAP_DEPTH + 1);
  localparam int IW   = AW + 2;
  localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;
  localparam int EW   = $bits(entry_t);

  logic [CW-1:0]       count_q, count_d;
  logic [CAP_BITS-1:0] cap_q;
  logic [AW-1:0]       pos_q, pos_d;
  entry_t              cur_q, cur_d;
  entry_t              lch_q;
  rsp_t                res_q, res_d;
  rsp_t                out_q;
  logic                out_valid_q;

  logic [AW-1:0]       parent_idx;
  logic [IW-1:0]       l_idx, r_idx;
  logic                left_ok, right_ok;
  logic                left_less, right_less;
  entry_t              min_lc, best;
  logic [AW-1:0]       best_idx;
  logic [AW-1:0]       rd_addr;
  logic [EW-1:0]       rd_raw;
  entry_t              rd_ent;
  entry_t              wr_ent;

  assign rd_ent = entry_t'(rd_raw);

  // Tree index arithmetic
  assign parent_idx = AW'((pos_q - AW'(1)) >> 1);
  assign l_idx      = {1'b0, pos_q, 1'b1};
  assign r_idx      = l_idx + IW'(1);
  assign left_ok    = (l_idx < IW'(count_q));
  assign right_ok   = (r_idx < IW'(count_q));

  // Sift-down choice: left child first, then right, strict less-than
  assign left_less  = left_ok && (lch_q.key < cur_q.key);
  assign min_lc     = left_less ? lch_q : cur_q;
  assign right_less = right_ok && (rd_ent.key < min_lc.key);
  assign best       = right_less ? rd_ent : lch_q;
  assign best_idx   = right_less ? r_idx[AW-1:0] : l_idx[AW-1:0];

  // Status to the controller
  always_comb begin
    stat_o.full     = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q >= CW'(HEAP_DEPTH));
    stat_o.empty    = (count_q == '0);
    stat_o.pos_zero = (pos_q == '0);
    stat_o.left_ok  = left_ok;
    stat_o.right_ok = right_ok;
    stat_o.up_less  = (cur_q.key < rd_ent.key);
    stat_o.dn_move  = left_less || right_less;
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  // RAM address and write data select
  always_comb begin
    case (cmd_i.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = count_q[AW-1:0];
      RD_PARENT: rd_addr = parent_idx;
      RD_LEFT:   rd_addr = l_idx[AW-1:0];
      RD_RIGHT:  rd_addr = r_idx[AW-1:0];
      default:   rd_addr = '0;
    endcase
    case (cmd_i.wr_sel)
      WR_CUR:  wr_ent = cur_q;
      WR_RD:   wr_ent = rd_ent;
      WR_BEST: wr_ent = best;
      default: wr_ent = cur_q;
    endcase
  end

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (pos_q),
    .wr_data_i (wr_ent),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw)
  );

  // Working registers next state
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    res_d   = res_q;
    if (cmd_i.push_start) begin
      cur_d   = '{key: in_word_i.key, handle: in_word_i.handle};
      pos_d   = count_q[AW-1:0];
      count_d = count_q + CW'(1);
      res_d   = '{result_valid: 1'b0, out_key: '0, out_handle: '0, status: ST_OK};
    end
    if (cmd_i.pop_start) begin
      count_d = count_q - CW'(1);
      pos_d   = '0;
    end
    if (cmd_i.res_full) begin
      res_d = '{result_valid: 1'b0, out_key: '0, out_handle: '0, status: ST_FULL};
    end
    if (cmd_i.res_empty) begin
      res_d = '{result_valid: 1'b0, out_key: '0, out_handle: '0, status: ST_EMPTY};
    end
    if (cmd_i.res_root) begin
      res_d = '{result_valid: 1'b1, out_key: rd_ent.key, out_handle: rd_ent.handle,
                status: ST_OK};
    end
    if (cmd_i.cur_load) begin
      cur_d = rd_ent;
    end
    if (cmd_i.pos_up) begin
      pos_d = parent_idx;
    end
    if (cmd_i.pos_down) begin
      pos_d = best_idx;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cur_q <= cur_d;
    res_q <= res_d;
    if (cmd_i.lch_load) begin
      lch_q <= rd_ent;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/bmhq_ctrl.sv
`default_nettype none

module bmhq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_opcode_i,
  output logic                 in_ready_o,
  input  wire bmhq_pkg::stat_t stat_i,
  output bmhq_pkg::cmd_t       cmd_o
);

  import bmhq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_UP_CHK   = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_POP_ROOT = 9'b000001000,
    S_POP_LAST = 9'b000010000,
    S_DN_L     = 9'b000100000,
    S_DN_R     = 9'b001000000,
    S_DN_CMP   = 9'b010000000,
    S_FIN      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_PUSH) begin
            if (stat_i.full) begin
              cmd_o.res_full = 1'b1;
              state_d        = S_FIN;
            end else begin
              cmd_o.push_start = 1'b1;
              state_d          = S_UP_CHK;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.res_empty = 1'b1;
              state_d         = S_FIN;
            end else begin
              cmd_o.pop_start = 1'b1;
              cmd_o.rd_en     = 1'b1;
              cmd_o.rd_sel    = RD_ROOT;
              state_d         = S_POP_ROOT;
            end
          end
        end
      end
      // Sift-up: fetch parent, or settle at the root
      S_UP_CHK: begin
        if (stat_i.pos_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_CUR;
          state_d      = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PARENT;
          state_d      = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.up_less) begin
          cmd_o.wr_sel = WR_RD;
          cmd_o.pos_up = 1'b1;
          state_d      = S_UP_CHK;
        end else begin
          cmd_o.wr_sel = WR_CUR;
          state_d      = S_FIN;
        end
      end
      // Pop: root arrives, then fetch the last entry
      S_POP_ROOT: begin
        cmd_o.res_root = 1'b1;
        if (stat_i.empty) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LAST;
          state_d      = S_POP_LAST;
        end
      end
      S_POP_LAST: begin
        cmd_o.cur_load = 1'b1;
        state_d        = S_DN_L;
      end
      // Sift-down: fetch children, compare, move one level
      S_DN_L: begin
        if (stat_i.left_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
          state_d      = S_DN_R;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_CUR;
          state_d      = S_FIN;
        end
      end
      S_DN_R: begin
        cmd_o.lch_load = 1'b1;
        if (stat_i.right_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_RIGHT;
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.dn_move) begin
          cmd_o.wr_sel   = WR_BEST;
          cmd_o.pos_down = 1'b1;
          state_d        = S_DN_L;
        end else begin
          cmd_o.wr_sel = WR_CUR;
          state_d      = S_FIN;
        end
      end
      // Hand the word to the output register once it is free
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue.
// Input channel (in_valid_i/in_ready_o/in_word_i): one word is a push of
// key and handle, or a pop of the smallest key. Every input word yields
// exactly one output word on out_valid_o/out_ready_i/out_word_o, in order:
// a pop returns the root entry, a push returns status only; a push beyond
// the capacity reports full, a pop on an empty heap reports empty.
// Configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the
// capacity limit; it is always ready and is meant to be written while idle.
// One word is worked at a time by a sequencer over a single-port-read RAM;
// an entry moves at most log2(HEAP_DEPTH) levels. A dropped push or a pop
// on empty skips the RAM; a push reads parent and writes a slot per level;
// a pop reads root and last entry, then per level both children (right if
// present) and writes a slot. The next word waits until the result loads.
// When the receiver stalls, the finished result waits in the output
// register and the next word is still worked; its result waits in turn.
// Reset empties the heap and sets the capacity limit to 64; RAM contents
// are not cleared, so there is no clearing pass.
`default_nettype none

module binary_min_heap_queue #(
  parameter int HEAP_DEPTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire bmhq_pkg::req_t                in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bmhq_pkg::rsp_t                     out_word_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bmhq_pkg::CAP_BITS-1:0] cfg_data_i
);

  import bmhq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_word_i.opcode),
    .in_ready_o  (in_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bmhq_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

// File: rtl/bmhq_checker.sv
`default_nettype none

module bmhq_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_o,
  input  wire bmhq_pkg::req_t                in_word_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire bmhq_pkg::rsp_t                out_word_o,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_o,
  input  wire logic [bmhq_pkg::CAP_BITS-1:0] cfg_data_i
);

  import bmhq_pkg::*;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // Only one word in work: after an accept the input closes
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A delivered entry always reports ok
  a_popped_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.result_valid |-> out_word_o.status == ST_OK)
    else $error("popped entry with error status");

  // Words without an entry carry zero key and handle
  a_no_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.result_valid |->
      out_word_o.out_key == '0 && out_word_o.out_handle == '0)
    else $error("nonzero payload without entry");

  // Status code is one of ok, full, empty
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.status == ST_OK || out_word_o.status == ST_FULL ||
      out_word_o.status == ST_EMPTY)
    else $error("unknown status code");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (.*);

`default_nettype wire
